// ===== design/bmcs_pkg.sv =====
// ============================================================================
// bmcs_pkg
// Shared types and constants of the battery maintenance cycle sequencer.
// ============================================================================
package bmcs_pkg;

    localparam int LEVEL_W     = 7;
    localparam int PHASE_W     = 4;
    localparam int REPORT_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = LEVEL_W;

    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RESET   = 7'd80;
    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RESET    = 7'd10;
    localparam logic [LEVEL_W-1:0] RUNTIME_READ_LEVEL = 7'd79;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LEVEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LEVEL  = 1'b1;

    // report event codes
    localparam logic [REPORT_W-1:0] REPORT_NONE   = 2'd0;
    localparam logic [REPORT_W-1:0] REPORT_FIRST  = 2'd1;
    localparam logic [REPORT_W-1:0] REPORT_MIDDLE = 2'd2;
    localparam logic [REPORT_W-1:0] REPORT_FINAL  = 2'd3;

    // phase numbers as shown on phase_now
    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE           = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_START          = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_HOLD_HIGH      = 4'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_CHARGE_UP      = 4'd3;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DISCHARGE_DOWN = 4'd4;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DISCHARGE_LOW  = 4'd5;
    localparam logic [PHASE_W-1:0] PHASE_CODE_HOLD_LOW       = 4'd6;
    localparam logic [PHASE_W-1:0] PHASE_CODE_RECHARGE       = 4'd7;
    localparam logic [PHASE_W-1:0] PHASE_CODE_HOLD_FINAL     = 4'd8;

    typedef enum logic [8:0] {
        PH_IDLE           = 9'b000000001,
        PH_START          = 9'b000000010,
        PH_HOLD_HIGH      = 9'b000000100,
        PH_CHARGE_UP      = 9'b000001000,
        PH_DISCHARGE_DOWN = 9'b000010000,
        PH_DISCHARGE_LOW  = 9'b000100000,
        PH_HOLD_LOW       = 9'b001000000,
        PH_RECHARGE       = 9'b010000000,
        PH_HOLD_FINAL     = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic               maintenance_request;
        logic               autotest_request;
        logic [LEVEL_W-1:0] charge_level;
        logic               wait_expired;
    } poll_t;

    typedef struct packed {
        logic                charge_on;
        logic                discharge_on;
        logic                timer_run;
        logic                timer_clear;
        logic [REPORT_W-1:0] report_event;
        logic                param_check;
        logic                runtime_read;
        logic                runtime_end_read;
        logic                cycle_done;
        logic [PHASE_W-1:0]  phase_now;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   phase_entered;
        logic   charge_drive;
        logic   discharge_drive;
        logic   timer_enable;
        logic   params_checked;
        logic   runtime_armed;
    } seq_state_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_IDLE:           code = PHASE_CODE_IDLE;
            PH_START:          code = PHASE_CODE_START;
            PH_HOLD_HIGH:      code = PHASE_CODE_HOLD_HIGH;
            PH_CHARGE_UP:      code = PHASE_CODE_CHARGE_UP;
            PH_DISCHARGE_DOWN: code = PHASE_CODE_DISCHARGE_DOWN;
            PH_DISCHARGE_LOW:  code = PHASE_CODE_DISCHARGE_LOW;
            PH_HOLD_LOW:       code = PHASE_CODE_HOLD_LOW;
            PH_RECHARGE:       code = PHASE_CODE_RECHARGE;
            PH_HOLD_FINAL:     code = PHASE_CODE_HOLD_FINAL;
            default:           code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/bmcs_in_if.sv =====
// ============================================================================
// bmcs_in_if
// Valid/ready channel that carries one poll per beat.
// ============================================================================
interface bmcs_in_if
    import bmcs_pkg::*;
();
    logic  valid;
    logic  ready;
    poll_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bmcs_out_if.sv =====
// ============================================================================
// bmcs_out_if
// Valid/ready channel that carries one sequencer result per beat.
// ============================================================================
interface bmcs_out_if
    import bmcs_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bmcs_step.sv =====
// ============================================================================
// bmcs_step
// Next-state and result logic for one poll of the maintenance sequence.
// ============================================================================
module bmcs_step
    import bmcs_pkg::*;
(
    input  seq_state_t         st,
    input  poll_t              item,
    input  logic [LEVEL_W-1:0] high_level,
    input  logic [LEVEL_W-1:0] low_level,
    output seq_state_t         st_next,
    output result_t            res
);

    logic                clear;
    logic [REPORT_W-1:0] report;
    logic                pcheck;
    logic                rt_read;
    logic                rt_end;
    logic                done;
    phase_t              ph;

    always_comb
    begin
        st_next = st;
        clear   = 1'b0;
        report  = REPORT_NONE;
        pcheck  = 1'b0;
        rt_read = 1'b0;
        rt_end  = 1'b0;
        done    = 1'b0;
        ph      = (st.phase == PH_IDLE) ? PH_START : st.phase;

        if (item.maintenance_request)
        begin
            if (st.phase == PH_IDLE)
            begin
                st_next.charge_drive    = 1'b0;
                st_next.discharge_drive = 1'b0;
            end
            if (item.autotest_request)
            begin
                if (!st.params_checked)
                begin
                    st_next.params_checked = 1'b1;
                    pcheck                 = 1'b1;
                end
                st_next.phase = ph;
                case (ph)
                    PH_START:
                    begin
                        if (item.charge_level == high_level)
                            st_next.phase = PH_HOLD_HIGH;
                        else if (item.charge_level < high_level)
                            st_next.phase = PH_CHARGE_UP;
                        else
                            st_next.phase = PH_DISCHARGE_DOWN;
                    end
                    PH_HOLD_HIGH:
                    begin
                        if (!st.phase_entered)
                        begin
                            st_next.charge_drive    = 1'b0;
                            st_next.discharge_drive = 1'b0;
                            st_next.timer_enable    = 1'b1;
                            st_next.phase_entered   = 1'b1;
                        end
                        else if (item.wait_expired)
                        begin
                            report                = REPORT_FIRST;
                            st_next.phase         = PH_DISCHARGE_LOW;
                            st_next.phase_entered = 1'b0;
                        end
                    end
                    PH_CHARGE_UP, PH_DISCHARGE_DOWN:
                    begin
                        if (!st.phase_entered)
                        begin
                            st_next.charge_drive    = (ph == PH_CHARGE_UP);
                            st_next.discharge_drive = (ph == PH_DISCHARGE_DOWN);
                            st_next.phase_entered   = 1'b1;
                        end
                        else if (item.charge_level == high_level)
                        begin
                            st_next.phase         = PH_HOLD_HIGH;
                            st_next.phase_entered = 1'b0;
                        end
                    end
                    PH_DISCHARGE_LOW:
                    begin
                        if (!st.phase_entered)
                        begin
                            st_next.charge_drive    = 1'b0;
                            st_next.discharge_drive = 1'b1;
                            st_next.timer_enable    = 1'b0;
                            clear                   = 1'b1;
                            st_next.phase_entered   = 1'b1;
                        end
                        else
                        begin
                            // one-shot run-time read on the way down
                            if (item.charge_level == RUNTIME_READ_LEVEL && st.runtime_armed)
                            begin
                                rt_read               = 1'b1;
                                st_next.runtime_armed = 1'b0;
                            end
                            if (item.charge_level == low_level)
                            begin
                                st_next.phase         = PH_HOLD_LOW;
                                st_next.phase_entered = 1'b0;
                            end
                        end
                    end
                    PH_HOLD_LOW:
                    begin
                        if (!st.phase_entered)
                        begin
                            st_next.charge_drive    = 1'b0;
                            st_next.discharge_drive = 1'b0;
                            st_next.timer_enable    = 1'b1;
                            rt_end                  = 1'b1;
                            st_next.phase_entered   = 1'b1;
                        end
                        else if (item.wait_expired)
                        begin
                            report                = REPORT_MIDDLE;
                            st_next.phase         = PH_RECHARGE;
                            st_next.phase_entered = 1'b0;
                        end
                    end
                    PH_RECHARGE:
                    begin
                        if (!st.phase_entered)
                        begin
                            st_next.charge_drive    = 1'b1;
                            st_next.discharge_drive = 1'b0;
                            st_next.timer_enable    = 1'b0;
                            clear                   = 1'b1;
                            st_next.phase_entered   = 1'b1;
                        end
                        else if (item.charge_level == high_level)
                        begin
                            st_next.phase         = PH_HOLD_FINAL;
                            st_next.phase_entered = 1'b0;
                        end
                    end
                    PH_HOLD_FINAL:
                    begin
                        if (!st.phase_entered)
                        begin
                            st_next.charge_drive    = 1'b0;
                            st_next.discharge_drive = 1'b0;
                            st_next.timer_enable    = 1'b1;
                            st_next.phase_entered   = 1'b1;
                        end
                        else if (item.wait_expired)
                        begin
                            report                 = REPORT_FINAL;
                            st_next.phase_entered  = 1'b0;
                            st_next.timer_enable   = 1'b0;
                            clear                  = 1'b1;
                            st_next.params_checked = 1'b0;
                            st_next.runtime_armed  = 1'b1;
                            done                   = 1'b1;
                            st_next.phase          = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        st_next.phase         = PH_IDLE;
                        st_next.phase_entered = 1'b0;
                    end
                endcase
            end
        end

        res.charge_on        = st_next.charge_drive;
        res.discharge_on     = st_next.discharge_drive;
        res.timer_run        = st_next.timer_enable;
        res.timer_clear      = clear;
        res.report_event     = report;
        res.param_check      = pcheck;
        res.runtime_read     = rt_read;
        res.runtime_end_read = rt_end;
        res.cycle_done       = done;
        res.phase_now        = phase_code(st_next.phase);
    end

endmodule

// ===== design/battery_maintenance_cycle_sequencer_top.sv =====
// an accepted poll goes to the poll register, its result to the result register
// throughput: one poll per clock cycle while the result side keeps taking beats
// the poll register and the result register let a new poll in while a result waits
// reset clears the sequence state to idle with the run-time read armed,
// and sets high_level to 80 and low_level to 10
// ============================================================================
// battery_maintenance_cycle_sequencer_top
// Battery test sequencer: one poll in, one result out, with level registers.
// ============================================================================
module battery_maintenance_cycle_sequencer_top
    import bmcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    bmcs_in_if.sink                poll,
    bmcs_out_if.source             result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic               in_valid_reg;
    logic               in_valid_next;
    poll_t              in_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_data_reg;
    seq_state_t         state_reg;
    seq_state_t         state_next;
    result_t            step_res;
    logic [LEVEL_W-1:0] high_level_reg;
    logic [LEVEL_W-1:0] low_level_reg;
    logic               advance;
    logic               poll_beat;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready   = !in_valid_reg || advance;
    assign poll_beat    = poll.valid && poll.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (poll_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    bmcs_step u_step (
        .st         (state_reg),
        .item       (in_data_reg),
        .high_level (high_level_reg),
        .low_level  (low_level_reg),
        .st_next    (state_next),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.phase           <= PH_IDLE;
            state_reg.phase_entered   <= 1'b0;
            state_reg.charge_drive    <= 1'b0;
            state_reg.discharge_drive <= 1'b0;
            state_reg.timer_enable    <= 1'b0;
            state_reg.params_checked  <= 1'b0;
            state_reg.runtime_armed   <= 1'b1;
            high_level_reg            <= HIGH_LEVEL_RESET;
            low_level_reg             <= LOW_LEVEL_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HIGH_LEVEL: high_level_reg <= cfg_data;
                    CFG_LOW_LEVEL:  low_level_reg  <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (poll_beat)
            in_data_reg <= poll.data;
        if (advance)
            out_data_reg <= step_res;
    end

endmodule

// ===== design/bmcs_checker.sv =====
// ============================================================================
// bmcs_checker
// Port-level assertions on the sequencer, bound to the top level.
// ============================================================================
module bmcs_checker
    import bmcs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // with nothing waiting on the result side a poll is always taken
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("poll side stalled with an empty result register");

    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.charge_on && out_data.discharge_on))
        else $error("charge and discharge driven together");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.cycle_done |->
            out_data.report_event == REPORT_FINAL && out_data.timer_clear
            && out_data.phase_now == PHASE_CODE_IDLE && !out_data.timer_run)
        else $error("sequence end beat inconsistent");

    // the read level may also be the low level, which ends the discharge at once
    a_rt_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.runtime_read |->
            (out_data.phase_now == PHASE_CODE_DISCHARGE_LOW
             || out_data.phase_now == PHASE_CODE_HOLD_LOW)
            && out_data.discharge_on)
        else $error("run-time read outside the middle discharge");

endmodule

bind battery_maintenance_cycle_sequencer_top bmcs_checker u_bmcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (poll.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

// ===== bench/battery_maintenance_cycle_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// battery_maintenance_cycle_sequencer_top_tb
// Drives polls into the sequencer and checks every result beat against a
// cycle-level predictor of the test sequence or a typed row's result. A short
// table of directed polls walks one full maintenance cycle. Random polls
// follow, mostly steered toward the level the current phase waits for, under
// several level settings and with idle and stall patterns on both channels.
// ============================================================================
module battery_maintenance_cycle_sequencer_top_tb;
    import bmcs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 4;
    localparam int SEGMENTS     = 6;
    localparam int SEG_POLLS    = 238;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS_N   = 25;

    typedef struct packed {
        logic    typed;
        poll_t   item;
        result_t res;
    } poll_row_t;

    localparam result_t NO_CHECK   = '0;
    localparam result_t QUIET_IDLE = '0;
    localparam result_t START_HOLD = '{1'b0, 1'b0, 1'b0, 1'b0, REPORT_NONE, 1'b1,
                                       1'b0, 1'b0, 1'b0, PHASE_CODE_HOLD_HIGH};

    // one full cycle at the reset levels, then the discharge-down path
    localparam poll_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{1'b1, '{1'b0, 1'b1, 7'd0,   1'b0}, QUIET_IDLE},
        '{1'b1, '{1'b1, 1'b0, 7'd100, 1'b1}, QUIET_IDLE},
        '{1'b1, '{1'b1, 1'b1, 7'd80,  1'b0}, START_HOLD},
        '{1'b0, '{1'b1, 1'b1, 7'd0,   1'b1}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b0, 7'd127, 1'b1}, NO_CHECK},
        '{1'b0, '{1'b0, 1'b1, 7'd79,  1'b1}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd50,  1'b1}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd79,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd79,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd79,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd10,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd10,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd10,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd10,  1'b1}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd0,   1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd100, 1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd80,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd80,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd80,  1'b1}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd100, 1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd100, 1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd80,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd80,  1'b0}, NO_CHECK},
        '{1'b0, '{1'b1, 1'b1, 7'd127, 1'b1}, NO_CHECK},
        '{1'b0, '{1'b0, 1'b0, 7'd0,   1'b0}, NO_CHECK}
    };

    // level settings per random segment; the last one is drawn at random
    localparam int SEG_HIGH [SEGMENTS] = '{80, 100, 0, 127, 60, 0};
    localparam int SEG_LOW  [SEGMENTS] = '{10, 0, 100, 127, 79, 0};

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bmcs_in_if  poll_bus ();
    bmcs_out_if result_bus ();

    battery_maintenance_cycle_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted sequencer state and level registers
    logic [PHASE_W-1:0] seq_phase;
    logic               seq_entered;
    logic               seq_charge;
    logic               seq_discharge;
    logic               seq_timer;
    logic               seq_checked;
    logic               seq_armed;
    logic [LEVEL_W-1:0] high_lvl;
    logic [LEVEL_W-1:0] low_lvl;

    result_t due_outputs [$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_idle_pct;
    int      recv_stall_pct;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    task automatic step_sequencer(input poll_t p, output result_t r);
        logic [LEVEL_W-1:0] lvl;
        lvl = p.charge_level;
        r = '0;
        if (p.maintenance_request) begin
            if (seq_phase == PHASE_CODE_IDLE) begin
                seq_charge    = 1'b0;
                seq_discharge = 1'b0;
            end
            if (p.autotest_request) begin
                if (!seq_checked) begin
                    seq_checked   = 1'b1;
                    r.param_check = 1'b1;
                end
                if (seq_phase == PHASE_CODE_IDLE)
                    seq_phase = PHASE_CODE_START;
                case (seq_phase)
                    PHASE_CODE_START: begin
                        if (lvl == high_lvl)
                            seq_phase = PHASE_CODE_HOLD_HIGH;
                        else if (lvl < high_lvl)
                            seq_phase = PHASE_CODE_CHARGE_UP;
                        else
                            seq_phase = PHASE_CODE_DISCHARGE_DOWN;
                    end
                    PHASE_CODE_HOLD_HIGH: begin
                        if (!seq_entered) begin
                            seq_charge    = 1'b0;
                            seq_discharge = 1'b0;
                            seq_timer     = 1'b1;
                            seq_entered   = 1'b1;
                        end
                        else if (p.wait_expired) begin
                            r.report_event = REPORT_FIRST;
                            seq_phase      = PHASE_CODE_DISCHARGE_LOW;
                            seq_entered    = 1'b0;
                        end
                    end
                    PHASE_CODE_CHARGE_UP, PHASE_CODE_DISCHARGE_DOWN: begin
                        if (!seq_entered) begin
                            seq_charge    = (seq_phase == PHASE_CODE_CHARGE_UP);
                            seq_discharge = (seq_phase == PHASE_CODE_DISCHARGE_DOWN);
                            seq_entered   = 1'b1;
                        end
                        else if (lvl == high_lvl) begin
                            seq_phase   = PHASE_CODE_HOLD_HIGH;
                            seq_entered = 1'b0;
                        end
                    end
                    PHASE_CODE_DISCHARGE_LOW: begin
                        if (!seq_entered) begin
                            seq_charge    = 1'b0;
                            seq_discharge = 1'b1;
                            seq_timer     = 1'b0;
                            r.timer_clear = 1'b1;
                            seq_entered   = 1'b1;
                        end
                        else begin
                            if (lvl == RUNTIME_READ_LEVEL && seq_armed) begin
                                r.runtime_read = 1'b1;
                                seq_armed      = 1'b0;
                            end
                            if (lvl == low_lvl) begin
                                seq_phase   = PHASE_CODE_HOLD_LOW;
                                seq_entered = 1'b0;
                            end
                        end
                    end
                    PHASE_CODE_HOLD_LOW: begin
                        if (!seq_entered) begin
                            seq_charge         = 1'b0;
                            seq_discharge      = 1'b0;
                            seq_timer          = 1'b1;
                            r.runtime_end_read = 1'b1;
                            seq_entered        = 1'b1;
                        end
                        else if (p.wait_expired) begin
                            r.report_event = REPORT_MIDDLE;
                            seq_phase      = PHASE_CODE_RECHARGE;
                            seq_entered    = 1'b0;
                        end
                    end
                    PHASE_CODE_RECHARGE: begin
                        if (!seq_entered) begin
                            seq_charge    = 1'b1;
                            seq_discharge = 1'b0;
                            seq_timer     = 1'b0;
                            r.timer_clear = 1'b1;
                            seq_entered   = 1'b1;
                        end
                        else if (lvl == high_lvl) begin
                            seq_phase   = PHASE_CODE_HOLD_FINAL;
                            seq_entered = 1'b0;
                        end
                    end
                    PHASE_CODE_HOLD_FINAL: begin
                        if (!seq_entered) begin
                            seq_charge    = 1'b0;
                            seq_discharge = 1'b0;
                            seq_timer     = 1'b1;
                            seq_entered   = 1'b1;
                        end
                        else if (p.wait_expired) begin
                            r.report_event = REPORT_FINAL;
                            r.timer_clear  = 1'b1;
                            r.cycle_done   = 1'b1;
                            seq_entered    = 1'b0;
                            seq_timer      = 1'b0;
                            seq_checked    = 1'b0;
                            seq_armed      = 1'b1;
                            seq_phase      = PHASE_CODE_IDLE;
                        end
                    end
                    default: begin
                        seq_phase   = PHASE_CODE_IDLE;
                        seq_entered = 1'b0;
                    end
                endcase
            end
        end
        r.charge_on    = seq_charge;
        r.discharge_on = seq_discharge;
        r.timer_run    = seq_timer;
        r.phase_now    = seq_phase;
    endtask

    // random poll, steered toward the level the current phase is waiting for
    function automatic poll_t make_poll();
        poll_t p;
        int    goal;
        int    roll;
        int    near;
        p.maintenance_request = ($urandom_range(99) < 94);
        p.autotest_request    = ($urandom_range(99) < 90);
        p.wait_expired        = ($urandom_range(99) < 40);
        p.charge_level        = LEVEL_W'($urandom_range(100));
        case (seq_phase)
            PHASE_CODE_IDLE, PHASE_CODE_START, PHASE_CODE_CHARGE_UP,
            PHASE_CODE_DISCHARGE_DOWN, PHASE_CODE_RECHARGE:
                goal = int'(high_lvl);
            PHASE_CODE_DISCHARGE_LOW:
                goal = (seq_armed && $urandom_range(99) < 40) ?
                       int'(RUNTIME_READ_LEVEL) : int'(low_lvl);
            default:
                goal = int'(p.charge_level);
        endcase
        roll = $urandom_range(99);
        // a goal above 100, the top of the drawn levels, is left unmet on purpose
        if (goal <= 100) begin
            if (roll < 45) begin
                p.charge_level = LEVEL_W'(goal);
            end
            else if (roll < 60) begin
                near = goal + $urandom_range(4) - 2;
                if (near < 0)
                    near = 0;
                if (near > 100)
                    near = 100;
                p.charge_level = LEVEL_W'(near);
            end
        end
        return p;
    endfunction

    task automatic send_poll(input poll_t p, input logic typed, input result_t typed_res);
        result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            poll_bus.valid <= 1'b0;
            @(posedge clk);
        end
        poll_bus.valid <= 1'b1;
        poll_bus.data  <= p;
        @(posedge clk);
        while (!poll_bus.ready)
            @(posedge clk);
        step_sequencer(p, pred);
        due_outputs.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain_results();
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_levels(input logic [LEVEL_W-1:0] hi, input logic [LEVEL_W-1:0] lo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HIGH_LEVEL;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_LOW_LEVEL;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_we    <= 1'b0;
        high_lvl = hi;
        low_lvl  = lo;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : watch_results
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (due_outputs.size() == 0) begin
                $error("result beat with no poll outstanding");
                mismatches++;
            end
            else begin
                want = due_outputs.pop_front();
                check_field("charge_on", 8'(want.charge_on),
                            8'(result_bus.data.charge_on));
                check_field("discharge_on", 8'(want.discharge_on),
                            8'(result_bus.data.discharge_on));
                check_field("timer_run", 8'(want.timer_run),
                            8'(result_bus.data.timer_run));
                check_field("timer_clear", 8'(want.timer_clear),
                            8'(result_bus.data.timer_clear));
                check_field("report_event", 8'(want.report_event),
                            8'(result_bus.data.report_event));
                check_field("param_check", 8'(want.param_check),
                            8'(result_bus.data.param_check));
                check_field("runtime_read", 8'(want.runtime_read),
                            8'(result_bus.data.runtime_read));
                check_field("runtime_end_read", 8'(want.runtime_end_read),
                            8'(result_bus.data.runtime_end_read));
                check_field("cycle_done", 8'(want.cycle_done),
                            8'(result_bus.data.cycle_done));
                check_field("phase_now", 8'(want.phase_now),
                            8'(result_bus.data.phase_now));
            end
        end
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        poll_t p;
        send_idle_pct  = 15;
        recv_stall_pct = 68;
        seq_phase      = PHASE_CODE_IDLE;
        seq_entered    = 1'b0;
        seq_charge     = 1'b0;
        seq_discharge  = 1'b0;
        seq_timer      = 1'b0;
        seq_checked    = 1'b0;
        seq_armed      = 1'b1;
        high_lvl       = HIGH_LEVEL_RESET;
        low_lvl        = LOW_LEVEL_RESET;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_HIGH_LEVEL;
        cfg_data         <= '0;
        poll_bus.valid   <= 1'b0;
        poll_bus.data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS_N; i++)
            send_poll(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].res);

        for (int s = 0; s < SEGMENTS; s++) begin
            // sender light and receiver heavy, then swapped, then no idling
            send_idle_pct  = (s < 2) ? 15 : (s < 4) ? 68 : 0;
            recv_stall_pct = (s < 2) ? 68 : (s < 4) ? 15 : 0;
            if (s > 0) begin
                poll_bus.valid <= 1'b0;
                drain_results();
                if (s == SEGMENTS - 1)
                    write_levels(LEVEL_W'($urandom_range(100)),
                                 LEVEL_W'($urandom_range(100)));
                else
                    write_levels(LEVEL_W'(SEG_HIGH[s]), LEVEL_W'(SEG_LOW[s]));
            end
            for (int n = 0; n < SEG_POLLS; n++) begin
                p = make_poll();
                send_poll(p, 1'b0, NO_CHECK);
            end
        end

        poll_bus.valid <= 1'b0;
        drain_results();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/bmcs_pkg.sv
design/bmcs_in_if.sv
design/bmcs_out_if.sv
design/bmcs_step.sv
design/battery_maintenance_cycle_sequencer_top.sv
design/bmcs_checker.sv
bench/battery_maintenance_cycle_sequencer_top_tb.sv
